>>> design/gnp_pkg.sv
// ----------------------------------------------------------------------------
// Greedy neighbor pairing: shared package
// Field widths, register indexes, reset values, the configuration struct and
// the struct that connects the pairing control to the bitmap memory.
// ----------------------------------------------------------------------------
package gnp_pkg;

  localparam int ID_W        = 20;  // node id, pair members
  localparam int POS_W       = 8;   // position in an adjacency list
  localparam int RAW_W       = 32;  // raw neighbor id
  localparam int NUM_W       = 19;  // emitted pair number
  localparam int CNT_W       = 20;  // internal pair counter
  localparam int NODE_CNT_W  = 21;  // node_count register
  localparam int DEG_W       = 9;   // degree_limit register
  localparam int CFG_DATA_W  = 21;  // widest register
  localparam int REG_IDX_W   = 2;

  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 64;

  // The bitmap is stored in rows of 32 flags.
  localparam int ROW_W       = 32;
  localparam int ROW_SHIFT   = 5;

  localparam int ID_SPACE      = 1 << ID_W;
  localparam int DEF_MAX_NODES = 1048576;

  localparam logic [REG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEGREE_LIMIT = 2'd2;

  typedef enum logic {
    MODE_NEIGHBOR = 1'b0,
    MODE_COEXPAND = 1'b1
  } mode_t;

  localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST   = 21'd1048576;
  localparam logic [DEG_W-1:0]      DEGREE_LIMIT_RST = 9'd64;

  typedef struct packed {
    mode_t                 mode;
    logic [NODE_CNT_W-1:0] node_count;
    logic [DEG_W-1:0]      degree_limit;
  } cfg_t;

  // Request to mark both members of a new pair in the bitmap.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] second;
  } mark_req_t;

endpackage

>>> design/greedy_neighbor_pairing_core.sv
// ----------------------------------------------------------------------------
// Greedy neighbor pairing core
// Pairs nodes greedily from streamed adjacency list entries and emits each
// new pair with its running number.
//
//   Port group   Dir   Carries
//   s_axis       in    one adjacency list entry per request
//   m_axis       out   one new pair per request
//   cfg          in    register writes (mode, node_count, degree_limit)
//
// An entry that forms no pair makes room for the next entry as it leaves; an
// entry that forms a pair keeps s_tready low while it leaves, because both
// members are marked through the bitmap's single write port. A result passes
// through the entry register and then the output register.
// After reset a clearing sweep writes one bitmap row per cycle over all
// ceil(min(MAX_NODES, 2^20) / 32) rows (32768 at the default), with s_tready
// low; configuration writes are taken meanwhile.
// While a result waits in the output register the next entry is still taken;
// only a pairing entry waits for the output register to free.
// ----------------------------------------------------------------------------
module greedy_neighbor_pairing_core #(
  parameter int MAX_NODES = gnp_pkg::DEF_MAX_NODES
) (
  input  logic                           clk,
  input  logic                           rst,
  // [19:0] parent_id, [27:20] neighbor_position, [59:28] neighbor_id
  input  logic [gnp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [19:0] first_member, [39:20] second_member, [58:40] pair_number
  output logic [gnp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [gnp_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [gnp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gnp_pkg::*;

  cfg_t             cfg;
  mark_req_t        mark;
  logic             bitmap_ready;
  logic             rd_bit_neighbor;
  logic             rd_bit_parent;
  logic             accept;
  logic             out_free;
  logic             res_valid;
  logic [ID_W-1:0]  res_first;
  logic [ID_W-1:0]  res_second;
  logic [NUM_W-1:0] res_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_NEIGHBOR;
      cfg.node_count   <= NODE_COUNT_RST;
      cfg.degree_limit <= DEGREE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:         cfg.mode         <= mode_t'(cfg_wdata[0]);
        REG_NODE_COUNT:   cfg.node_count   <= cfg_wdata[NODE_CNT_W-1:0];
        REG_DEGREE_LIMIT: cfg.degree_limit <= cfg_wdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  gnp_bitmap #(
    .MAX_NODES (MAX_NODES)
  ) u_bitmap (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_id_a  (s_tdata[ID_W+POS_W +: ID_W]),
    .rd_id_b  (s_tdata[ID_W-1:0]),
    .rd_bit_a (rd_bit_neighbor),
    .rd_bit_b (rd_bit_parent),
    .mark     (mark),
    .ready    (bitmap_ready)
  );

  gnp_match #(
    .MAX_NODES (MAX_NODES)
  ) u_match (
    .clk                  (clk),
    .rst                  (rst),
    .cfg                  (cfg),
    .bitmap_ready         (bitmap_ready),
    .in_valid             (s_tvalid),
    .in_parent_id         (s_tdata[ID_W-1:0]),
    .in_neighbor_position (s_tdata[ID_W +: POS_W]),
    .in_neighbor_id       (s_tdata[ID_W+POS_W +: RAW_W]),
    .in_ready             (s_tready),
    .rd_bit_neighbor      (rd_bit_neighbor),
    .rd_bit_parent        (rd_bit_parent),
    .mark                 (mark),
    .out_free             (out_free),
    .res_valid            (res_valid),
    .res_first            (res_first),
    .res_second           (res_second),
    .res_number           (res_number)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {(OUT_DATA_W - 2 * ID_W - NUM_W)'(0), res_number, res_second, res_first};
    end
  end

endmodule

>>> design/gnp_bitmap.sv
// ----------------------------------------------------------------------------
// Greedy neighbor pairing: paired-node bitmap
// One flag per node in a synchronous memory of 32-bit rows. Two read ports
// with registered data, one bit-masked write port, a clearing sweep after
// reset, and a one-entry holding register for the second member of a pair.
// ----------------------------------------------------------------------------
module gnp_bitmap #(
  parameter int MAX_NODES = gnp_pkg::DEF_MAX_NODES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [gnp_pkg::ID_W-1:0] rd_id_a,
  input  logic [gnp_pkg::ID_W-1:0] rd_id_b,
  output logic                     rd_bit_a,
  output logic                     rd_bit_b,
  input  gnp_pkg::mark_req_t       mark,
  output logic                     ready
);
  import gnp_pkg::*;

  localparam int MapDepth = (MAX_NODES < ID_SPACE) ? MAX_NODES : ID_SPACE;
  localparam int Rows     = (MapDepth + ROW_W - 1) / ROW_W;
  localparam int RowAw    = (Rows > 1) ? $clog2(Rows) : 1;

  logic [ROW_W-1:0]     mem [Rows];
  logic                 clearing;
  logic [RowAw-1:0]     clr_row;
  logic                 b_pend;
  logic [ID_W-1:0]      b_id;
  logic [ROW_W-1:0]     row_a;
  logic [ROW_W-1:0]     row_b;
  logic [ROW_SHIFT-1:0] sel_a;
  logic [ROW_SHIFT-1:0] sel_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
      b_pend   <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
        if (clr_row == RowAw'(Rows - 1)) begin
          clearing <= 1'b0;
        end
      end
      b_pend <= mark.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mark.valid) begin
      b_id <= mark.second;
    end
  end

  // The first member is marked in the cycle of the request, the second one
  // in the cycle after; the control never issues requests back to back.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_row] <= '0;
    end else if (mark.valid) begin
      mem[mark.first[ROW_SHIFT +: RowAw]][mark.first[ROW_SHIFT-1:0]] <= 1'b1;
    end else if (b_pend) begin
      mem[b_id[ROW_SHIFT +: RowAw]][b_id[ROW_SHIFT-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_a <= mem[rd_id_a[ROW_SHIFT +: RowAw]];
      row_b <= mem[rd_id_b[ROW_SHIFT +: RowAw]];
      sel_a <= rd_id_a[ROW_SHIFT-1:0];
      sel_b <= rd_id_b[ROW_SHIFT-1:0];
    end
  end

  assign rd_bit_a = row_a[sel_a];
  assign rd_bit_b = row_b[sel_b];
  assign ready    = !clearing;

  a_mark_port_free: assert property (@(posedge clk) disable iff (rst)
    mark.valid |-> (!b_pend && !clearing))
    else $error("bitmap mark request while the write port is busy");

  a_no_read_in_clear: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !clearing)
    else $error("bitmap read during clearing sweep");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_row) == RowAw'(Rows - 1))
    else $error("clearing sweep ended early");

endmodule

>>> design/gnp_match.sv
// ----------------------------------------------------------------------------
// Greedy neighbor pairing: pairing control
// Holds the entry whose bitmap rows are being read, applies the neighbor and
// coexpand rules with forwarding of the last pair, and keeps the list state.
// ----------------------------------------------------------------------------
module gnp_match #(
  parameter int MAX_NODES = gnp_pkg::DEF_MAX_NODES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gnp_pkg::cfg_t             cfg,
  input  logic                      bitmap_ready,
  input  logic                      in_valid,
  input  logic [gnp_pkg::ID_W-1:0]  in_parent_id,
  input  logic [gnp_pkg::POS_W-1:0] in_neighbor_position,
  input  logic [gnp_pkg::RAW_W-1:0] in_neighbor_id,
  output logic                      in_ready,
  input  logic                      rd_bit_neighbor,
  input  logic                      rd_bit_parent,
  output gnp_pkg::mark_req_t        mark,
  input  logic                      out_free,
  output logic                      res_valid,
  output logic [gnp_pkg::ID_W-1:0]  res_first,
  output logic [gnp_pkg::ID_W-1:0]  res_second,
  output logic [gnp_pkg::NUM_W-1:0] res_number
);
  import gnp_pkg::*;

  localparam int MapDepth = (MAX_NODES < ID_SPACE) ? MAX_NODES : ID_SPACE;
  localparam logic [NODE_CNT_W-1:0] DepthLimit = NODE_CNT_W'(MapDepth);

  logic             s1_valid;
  logic [ID_W-1:0]  s1_parent;
  logic [POS_W-1:0] s1_pos;
  logic [RAW_W-1:0] s1_nb;

  logic             list_done;
  logic [ID_W-1:0]  pending_member;
  logic             pending_valid;
  logic             pending_stale;
  logic [CNT_W-1:0] pair_counter;
  logic             last_valid;
  logic [ID_W-1:0]  last_first;
  logic [ID_W-1:0]  last_second;

  logic [NODE_CNT_W-1:0] limit;
  logic [ID_W-1:0]       v;
  logic new_list, ld, pv;
  logic v_paired, p_paired, base_ok;
  logic pend_live, emit, advance, accept, set_pend;
  logic list_done_next, pending_valid_next, pending_stale_next;

  always_comb begin
    limit    = (cfg.node_count > DepthLimit) ? DepthLimit : cfg.node_count;
    v        = s1_nb[ID_W-1:0];
    new_list = (s1_pos == '0);
    ld       = new_list ? 1'b0 : list_done;
    pv       = new_list ? 1'b0 : pending_valid;

    // Marks of the last pair may not have reached the memory at read time.
    v_paired = rd_bit_neighbor ||
               (last_valid && (v == last_first || v == last_second));
    p_paired = rd_bit_parent ||
               (last_valid && (s1_parent == last_first || s1_parent == last_second));

    base_ok = ({1'b0, s1_pos} < cfg.degree_limit) &&
              (s1_nb < RAW_W'(limit)) &&
              (v != s1_parent) && !v_paired;

    pend_live = pv && ({1'b0, pending_member} < limit) && !pending_stale;

    emit               = 1'b0;
    set_pend           = 1'b0;
    list_done_next     = ld;
    pending_valid_next = pv;
    pending_stale_next = pending_stale;
    res_first          = s1_parent;

    if (cfg.mode == MODE_NEIGHBOR) begin
      if (base_ok && !ld && ({1'b0, s1_parent} < limit) && !p_paired) begin
        emit           = 1'b1;
        list_done_next = 1'b1;
        if (pending_member == s1_parent || pending_member == v) begin
          pending_stale_next = 1'b1;
        end
      end
    end else begin
      res_first = pending_member;
      if (base_ok) begin
        pending_valid_next = pend_live;
        if (!pend_live) begin
          set_pend           = 1'b1;
          pending_valid_next = 1'b1;
          pending_stale_next = 1'b0;
        end else if (v != pending_member) begin
          emit               = 1'b1;
          pending_valid_next = 1'b0;
        end
      end
    end

    advance  = s1_valid && !(emit && !out_free);
    in_ready = bitmap_ready && (!s1_valid || (advance && !emit));
    accept   = in_valid && in_ready;
  end

  assign res_valid   = s1_valid && emit && advance;
  assign res_second  = v;
  assign res_number  = pair_counter[NUM_W-1:0];
  assign mark.valid  = res_valid;
  assign mark.first  = res_first;
  assign mark.second = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      list_done      <= 1'b0;
      pending_member <= '0;
      pending_valid  <= 1'b0;
      pending_stale  <= 1'b0;
      pair_counter   <= '0;
      last_valid     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        list_done     <= list_done_next;
        pending_valid <= pending_valid_next;
        pending_stale <= pending_stale_next;
        if (set_pend) begin
          pending_member <= v;
        end
        if (emit) begin
          pair_counter <= pair_counter + 1'b1;
          last_valid   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_parent <= in_parent_id;
      s1_pos    <= in_neighbor_position;
      s1_nb     <= in_neighbor_id;
    end
    if (res_valid) begin
      last_first  <= res_first;
      last_second <= v;
    end
  end

  a_marks_spaced: assert property (@(posedge clk) disable iff (rst)
    mark.valid |=> !mark.valid)
    else $error("two pair marks in consecutive cycles");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> pair_counter == CNT_W'($past(pair_counter) + 1'b1))
    else $error("pair counter did not advance with a new pair");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_nb) && $stable(s1_parent)))
    else $error("stalled entry lost or changed");

endmodule
